>>> rtl/cdrs_pkg.sv
`default_nettype none

package cdrs_pkg;

    // Field widths
    localparam int SECTOR_W = 21;
    localparam int BLOCK_W  = 19;
    localparam int COUNT_W  = 8;
    localparam int TICK_W   = 8;
    localparam int TRY_W    = 2;
    localparam int FLAG_W   = 4;
    localparam int STATUS_W = 8;
    localparam int VALUE_W  = 8;
    localparam int KIND_W   = 3;

    // Stream and register port widths
    localparam int S_TDATA_W  = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int MAX_RESULTS         = 7;
    localparam int BURST_CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int MAX_REQUEST_SECTORS = 255;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STATUS_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_TIMEOUT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT    = 2'd2;

    localparam logic [TICK_W-1:0] STATUS_TIMEOUT_RST = 8'd100;
    localparam logic [TICK_W-1:0] DATA_TIMEOUT_RST   = 8'd200;
    localparam logic [TRY_W-1:0]  RETRY_LIMIT_RST    = 2'd3;

    // Request opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Flag port codes and status bits
    localparam logic [FLAG_W-1:0] FLAGS_STATUS_READY = 4'hB;
    localparam logic [FLAG_W-1:0] FLAGS_NO_DATA      = 4'hF;
    localparam int                STATUS_DISK_BIT    = 6;

    // Drive command bytes
    localparam logic [VALUE_W-1:0] CMD_GET_STATUS = 8'h40;
    localparam logic [VALUE_W-1:0] CMD_SET_MODE   = 8'h50;
    localparam logic [VALUE_W-1:0] MODE_ARG       = 8'h01;
    localparam logic [VALUE_W-1:0] CMD_READ       = 8'hC0;
    localparam logic [VALUE_W-1:0] READ_LEN_HI    = 8'h00;
    localparam logic [VALUE_W-1:0] READ_LEN_MID   = 8'h00;
    localparam logic [VALUE_W-1:0] READ_LEN_LO    = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STATUS,
        PH_SETMODE,
        PH_DATA,
        PH_RESTART
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        K_CMD,
        K_SERVE,
        K_LOAD,
        K_DONE,
        K_FAIL
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] items;
        logic [BURST_CNT_W-1:0]    count;
    } burst_t;

    typedef struct packed {
        logic                op;
        logic                is_read;
        logic [SECTOR_W-1:0] start_sector;
        logic [COUNT_W-1:0]  sector_count;
        logic [FLAG_W-1:0]   port_flags;
        logic [STATUS_W-1:0] status_byte;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] status_timeout;
        logic [TICK_W-1:0] data_timeout;
        logic [TRY_W-1:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] minute;
        logic [VALUE_W-1:0] second;
        logic [VALUE_W-1:0] frame;
    } msf_t;

    typedef struct packed {
        phase_t phase;
        logic   cache_valid;
        logic   sectors_pending;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/cdrom_read_command_sequencer.sv
// CD drive read sequencer, host side.
// Input stream (s_*): one request per beat. s_tuser selects the request kind:
// a new read request or a timer tick carrying the sampled flag and status
// ports. Output stream (m_*): the results of each request as a burst of one
// to seven beats, m_tlast on the last beat of the burst. A request that
// causes nothing (tick while idle, request while busy) yields no beats.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the status timeout, data
// timeout or retry limit, one per write; write only while the block is idle.
// The first result of a request appears in the cycle after it is accepted.
// A request can be taken in the cycle the previous burst shows its last beat,
// if m_tready is high and the address converter is not busy. After every
// accepted new request, read or not and even one dropped while busy, the
// address converter (four register stages, block to BCD minute/second/frame)
// holds s_tready low while it settles.
// Reset: synchronous, active low; the sequencer returns to idle with no block
// cached and the registers at 100, 200 and 3.
// Stall: while m_tready is low the current beat holds and s_tready drops as
// soon as the burst register cannot take the next request's results.
`default_nettype none

module cdrom_read_command_sequencer
    import cdrs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] is_read, [21:1] start_sector, [29:22] sector_count,
    // [33:30] port_flags, [41:34] status_byte, [47:42] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] op
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] value
    output logic [VALUE_W-1:0]         m_tdata,
    // [2:0] kind
    output logic [KIND_W-1:0]          m_tuser,
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                cfg_reg;
    item_t               item;
    burst_t              burst;
    msf_t                msf;
    stat_t               stat;
    logic [SECTOR_W-1:0] next_sector;
    logic                take, msf_busy, can_load;

    // Unpack the request fields from the stream beat.
    assign item = '{op:           s_tuser,
                    is_read:      s_tdata[0],
                    start_sector: s_tdata[21:1],
                    sector_count: s_tdata[29:22],
                    port_flags:   s_tdata[33:30],
                    status_byte:  s_tdata[41:34]};

    // Take a request only when the burst register can hold its results and
    // the address converter has settled on the current sector.
    assign s_tready = can_load && !msf_busy;
    assign take     = s_tvalid && s_tready;

    // Configuration registers; writes to unused indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{status_timeout: STATUS_TIMEOUT_RST,
                         data_timeout:   DATA_TIMEOUT_RST,
                         retry_limit:    RETRY_LIMIT_RST};
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_STATUS_TIMEOUT: cfg_reg.status_timeout <= cfg_wdata;
                REG_DATA_TIMEOUT:   cfg_reg.data_timeout   <= cfg_wdata;
                REG_RETRY_LIMIT:    cfg_reg.retry_limit    <= cfg_wdata[TRY_W-1:0];
                default: ;
            endcase
        end
    end

    cdrs_msf u_msf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .reload      (take && item.op == OP_REQUEST),
        .next_sector (next_sector),
        .msf         (msf),
        .busy        (msf_busy)
    );

    cdrs_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_take     (take),
        .item        (item),
        .cfg         (cfg_reg),
        .msf         (msf),
        .burst       (burst),
        .next_sector (next_sector),
        .stat        (stat)
    );

    // Load the burst register only when the request produced results.
    cdrs_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && burst.count != '0),
        .burst_in (burst),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A busy sequence always has sectors still to fetch.
    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.phase != PH_IDLE |-> stat.sectors_pending)
        else $error("sequencer busy with no sectors left");

    // The cache is invalid for the whole data wait.
    a_data_wait_uncached: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.phase == PH_DATA |-> !stat.cache_valid)
        else $error("cache valid during data wait");

    // A fresh burst only follows an accepted request.
    a_burst_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || $past(s_tvalid && s_tready))
        else $error("result burst without a request");

    // No request is taken while the address converter is settling.
    a_no_take_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(take && item.op == OP_REQUEST) |-> !take)
        else $error("request taken while address converter busy");

endmodule

`default_nettype wire

>>> rtl/cdrs_msf.sv
`default_nettype none

// Block address to BCD minute/second/frame, four register stages.
module cdrs_msf
    import cdrs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                reload,
    input  wire logic [SECTOR_W-1:0] next_sector,
    output msf_t                     msf,
    output logic                     busy
);

    localparam int LAT   = 4;
    localparam int LAT_W = $clog2(LAT + 1);
    // floor(x/75) = (x * R75) >> 26 for x < 2^20
    localparam logic [19:0] R75 = 20'd894785;
    // floor(x/60) = (x * R60) >> 19 for x < 2^13
    localparam logic [13:0] R60 = 14'd8739;

    function automatic logic [VALUE_W-1:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  units;
        p     = 15'(v) * 15'd205;
        tens  = p[14:11];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    logic [LAT_W-1:0] guard_reg, guard_next;
    logic [19:0]      a1_reg;
    logic [12:0]      q1_reg, q2_reg;
    logic [6:0]       frm2_reg, frm3_reg, min2_reg, min3_reg;
    logic [5:0]       sec3_reg;
    msf_t             msf_reg;

    logic [19:0] addr;
    logic [39:0] prod75;
    logic [26:0] prod60;
    logic [19:0] frm_full;
    logic [12:0] sec_full;

    always_comb begin
        addr     = {1'b0, next_sector[SECTOR_W-1:2]} + 20'd150;
        prod75   = 40'(addr) * 40'(R75);
        frm_full = a1_reg - 20'(q1_reg) * 20'd75;
        prod60   = 27'(q1_reg) * 27'(R60);
        sec_full = q2_reg - 13'(min2_reg) * 13'd60;
    end

    always_comb begin
        guard_next = guard_reg;
        if (reload) begin
            guard_next = LAT_W'(LAT);
        end else if (guard_reg != '0) begin
            guard_next = guard_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg <= '0;
        end else begin
            guard_reg <= guard_next;
        end
    end

    always_ff @(posedge aclk) begin
        a1_reg   <= addr;
        q1_reg   <= prod75[38:26];
        q2_reg   <= q1_reg;
        frm2_reg <= frm_full[6:0];
        min2_reg <= prod60[25:19];
        frm3_reg <= frm2_reg;
        min3_reg <= min2_reg;
        sec3_reg <= sec_full[5:0];
        msf_reg  <= '{minute: to_bcd(min3_reg),
                      second: to_bcd({1'b0, sec3_reg}),
                      frame:  to_bcd(frm3_reg)};
    end

    assign msf  = msf_reg;
    assign busy = (guard_reg != '0);

endmodule

`default_nettype wire

>>> rtl/cdrs_step.sv
`default_nettype none

// Sequencer state and per-request decision logic.
module cdrs_step
    import cdrs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_take,
    input  wire item_t    item,
    input  wire cfg_t     cfg,
    input  wire msf_t     msf,
    output burst_t        burst,
    output logic [SECTOR_W-1:0] next_sector,
    output stat_t         stat
);

    function automatic result_t mk(input kind_t k, input logic [VALUE_W-1:0] v);
        return '{kind: k, value: v};
    endfunction

    function automatic burst_t one(input result_t r);
        burst_t b;
        b          = '0;
        b.items[0] = r;
        b.count    = BURST_CNT_W'(1);
        return b;
    endfunction

    // Optional load marker, a run of served quarters, then one closing result.
    function automatic burst_t pack_serves(input logic lead_load, input logic [1:0] first,
                                           input logic [2:0] n, input result_t tail);
        burst_t                 b;
        logic [BURST_CNT_W-1:0] pos;
        b   = '0;
        pos = '0;
        if (lead_load) begin
            b.items[pos] = mk(K_LOAD, '0);
            pos          = pos + 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < n) begin
                b.items[pos] = mk(K_SERVE, VALUE_W'(first + 2'(k)));
                pos          = pos + 1'b1;
            end
        end
        b.items[pos] = tail;
        b.count      = pos + 1'b1;
        return b;
    endfunction

    function automatic logic [2:0] serve_count(input logic [COUNT_W-1:0] left,
                                               input logic [1:0] offs);
        logic [2:0] room;
        room = 3'd4 - {1'b0, offs};
        return (left < COUNT_W'(room)) ? left[2:0] : room;
    endfunction

    phase_t              phase_reg, phase_next;
    logic [TRY_W-1:0]    tries_left_reg, tries_left_next;
    logic [TICK_W-1:0]   ticks_left_reg, ticks_left_next;
    logic                cache_valid_reg, cache_valid_next;
    logic [BLOCK_W-1:0]  cached_block_reg, cached_block_next;
    logic [SECTOR_W-1:0] next_sector_reg, next_sector_next;
    logic [COUNT_W-1:0]  sectors_left_reg, sectors_left_next;

    logic                is_tick, is_req, flag_ready, flag_nodata, disk_in;
    logic [COUNT_W-1:0]  req_left, req_left_after;
    logic [2:0]          req_n, load_n;
    logic [SECTOR_W-1:0] req_next_after;
    logic [TICK_W-1:0]   ticks_dec;
    burst_t              read_burst;

    always_comb begin
        is_tick     = in_take && (item.op == OP_TICK);
        is_req      = in_take && (item.op == OP_REQUEST);
        flag_ready  = (item.port_flags == FLAGS_STATUS_READY);
        flag_nodata = (item.port_flags == FLAGS_NO_DATA);
        disk_in     = item.status_byte[STATUS_DISK_BIT];
        req_left    = (32'(item.sector_count) > MAX_REQUEST_SECTORS)
                      ? COUNT_W'(MAX_REQUEST_SECTORS) : item.sector_count;
        req_n       = (cache_valid_reg &&
                       cached_block_reg == item.start_sector[SECTOR_W-1:2])
                      ? serve_count(req_left, item.start_sector[1:0]) : 3'd0;
        req_left_after = req_left - COUNT_W'(req_n);
        req_next_after = item.start_sector + SECTOR_W'(req_n);
        load_n      = serve_count(sectors_left_reg, next_sector_reg[1:0]);
        ticks_dec   = ticks_left_reg - TICK_W'(ticks_left_reg != '0);

        read_burst          = '0;
        read_burst.items[0] = mk(K_CMD, CMD_READ);
        read_burst.items[1] = mk(K_CMD, msf.minute);
        read_burst.items[2] = mk(K_CMD, msf.second);
        read_burst.items[3] = mk(K_CMD, msf.frame);
        read_burst.items[4] = mk(K_CMD, READ_LEN_HI);
        read_burst.items[5] = mk(K_CMD, READ_LEN_MID);
        read_burst.items[6] = mk(K_CMD, READ_LEN_LO);
        read_burst.count    = BURST_CNT_W'(MAX_RESULTS);
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg) inside
            PH_IDLE: begin
                if (is_req && item.is_read && req_left_after != '0) begin
                    phase_next = (cfg.retry_limit != '0) ? PH_STATUS : PH_IDLE;
                end
            end
            PH_STATUS, PH_SETMODE: begin
                if (is_tick) begin
                    if (!flag_ready) begin
                        if (ticks_dec == '0) begin
                            phase_next = PH_RESTART;
                        end
                    end else if (phase_reg == PH_STATUS) begin
                        phase_next = disk_in ? PH_SETMODE : PH_IDLE;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (is_tick && !flag_ready) begin
                    if (!flag_nodata) begin
                        phase_next = PH_IDLE;
                    end else if (ticks_dec == '0) begin
                        phase_next = PH_RESTART;
                    end
                end
            end
            PH_RESTART: begin
                if (is_tick) begin
                    phase_next = (tries_left_reg != '0) ? PH_STATUS : PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Results and data state
    always_comb begin
        burst             = '0;
        tries_left_next   = tries_left_reg;
        ticks_left_next   = ticks_left_reg;
        cache_valid_next  = cache_valid_reg;
        cached_block_next = cached_block_reg;
        next_sector_next  = next_sector_reg;
        sectors_left_next = sectors_left_reg;
        unique case (phase_reg) inside
            PH_IDLE: begin
                if (is_req) begin
                    if (!item.is_read) begin
                        burst = one(mk(K_FAIL, '0));
                    end else begin
                        next_sector_next  = req_next_after;
                        sectors_left_next = req_left_after;
                        if (req_left_after == '0) begin
                            burst = pack_serves(1'b0, item.start_sector[1:0], req_n,
                                                mk(K_DONE, '0));
                        end else if (cfg.retry_limit == '0) begin
                            tries_left_next = '0;
                            burst = pack_serves(1'b0, item.start_sector[1:0], req_n,
                                                mk(K_FAIL, '0));
                        end else begin
                            tries_left_next = cfg.retry_limit - 1'b1;
                            ticks_left_next = cfg.status_timeout;
                            burst = pack_serves(1'b0, item.start_sector[1:0], req_n,
                                                mk(K_CMD, CMD_GET_STATUS));
                        end
                    end
                end
            end
            PH_STATUS, PH_SETMODE: begin
                if (is_tick) begin
                    ticks_left_next = ticks_dec;
                    if (flag_ready) begin
                        if (phase_reg == PH_STATUS) begin
                            if (!disk_in) begin
                                burst = one(mk(K_FAIL, '0));
                            end else begin
                                burst.items[0]  = mk(K_CMD, CMD_SET_MODE);
                                burst.items[1]  = mk(K_CMD, MODE_ARG);
                                burst.count     = BURST_CNT_W'(2);
                                ticks_left_next = cfg.status_timeout;
                            end
                        end else begin
                            cache_valid_next = 1'b0;
                            burst            = read_burst;
                            ticks_left_next  = cfg.data_timeout;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (is_tick) begin
                    ticks_left_next = ticks_dec;
                    if (!flag_ready && !flag_nodata) begin
                        cache_valid_next  = 1'b1;
                        cached_block_next = next_sector_reg[SECTOR_W-1:2];
                        next_sector_next  = next_sector_reg + SECTOR_W'(load_n);
                        sectors_left_next = sectors_left_reg - COUNT_W'(load_n);
                        burst = pack_serves(1'b1, next_sector_reg[1:0], load_n,
                                            mk(K_DONE, '0));
                    end
                end
            end
            PH_RESTART: begin
                if (is_tick) begin
                    if (tries_left_reg == '0) begin
                        burst = one(mk(K_FAIL, '0));
                    end else begin
                        tries_left_next = tries_left_reg - 1'b1;
                        ticks_left_next = cfg.status_timeout;
                        burst           = one(mk(K_CMD, CMD_GET_STATUS));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            tries_left_reg   <= '0;
            ticks_left_reg   <= '0;
            cache_valid_reg  <= 1'b0;
            cached_block_reg <= '0;
            next_sector_reg  <= '0;
            sectors_left_reg <= '0;
        end else begin
            phase_reg        <= phase_next;
            tries_left_reg   <= tries_left_next;
            ticks_left_reg   <= ticks_left_next;
            cache_valid_reg  <= cache_valid_next;
            cached_block_reg <= cached_block_next;
            next_sector_reg  <= next_sector_next;
            sectors_left_reg <= sectors_left_next;
        end
    end

    assign next_sector = next_sector_reg;
    assign stat        = '{phase:           phase_reg,
                           cache_valid:     cache_valid_reg,
                           sectors_pending: (sectors_left_reg != '0)};

endmodule

`default_nettype wire

>>> rtl/cdrs_emit.sv
`default_nettype none

// Result register: holds one burst and shifts it out one result per beat.
module cdrs_emit
    import cdrs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire burst_t             burst_in,
    output logic                    can_load,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [VALUE_W-1:0]      m_tdata,
    output logic [KIND_W-1:0]       m_tuser,
    output logic                    m_tlast
);

    result_t [MAX_RESULTS-1:0] items_reg, items_next;
    logic [BURST_CNT_W-1:0]    count_reg, count_next;
    logic                      beat;

    assign beat     = m_tvalid && m_tready;
    assign can_load = (count_reg == '0) || (count_reg == BURST_CNT_W'(1) && m_tready);

    always_comb begin
        items_next = items_reg;
        count_next = count_reg;
        if (load) begin
            items_next = burst_in.items;
            count_next = burst_in.count;
        end else if (beat) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                items_next[i] = items_reg[i + 1];
            end
            items_next[MAX_RESULTS-1] = '0;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        items_reg <= items_next;
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tlast  = (count_reg == BURST_CNT_W'(1));
    assign m_tdata  = items_reg[0].value;
    assign m_tuser  = items_reg[0].kind;

endmodule

`default_nettype wire
